@@ src/gbmr_pkg.sv @@
// Shared widths, codes and constants of the generation best and mutation rate block.
package gbmr_pkg;

    localparam int LOSS_W  = 32;
    localparam int RATE_W  = 16;
    localparam int INDEX_W = 16;
    localparam int STAG_W  = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_RATE  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_RATE  = 2'd2;

    // Reset values of the configuration registers.
    localparam logic [LOSS_W-1:0] THRESHOLD_RST = 32'd3277;   // about 0.05 in Q16.16
    localparam logic [RATE_W-1:0] MIN_RATE_RST  = 16'd524;    // about 0.008 in Q0.16
    localparam logic [RATE_W-1:0] MAX_RATE_RST  = 16'd9830;   // about 0.15 in Q0.16

    // Rate factors in Q1.16: 1.04 and 1 / 1.02.
    localparam int FACTOR_W = 17;
    localparam int PROD_W   = RATE_W + FACTOR_W;
    localparam logic [FACTOR_W-1:0] GROW_Q16  = 17'd68157;
    localparam logic [FACTOR_W-1:0] DECAY_Q16 = 17'd64251;
    localparam logic [PROD_W-1:0]   ROUND_HALF = 33'd32768;

    localparam logic [STAG_W-1:0] STAG_MAX = {STAG_W{1'b1}};

endpackage

@@ src/generation_best_and_mutation_rate.sv @@
// Top level: running argmin of a generation's losses and adaptive mutation rate update.
//
// Usage: the input channel (in_valid, in_stall, loss, loss_infinite, last) takes one
// individual's loss per word, in index order; the word with last set closes the
// generation. Only that closing word produces an output word (top_index, min_loss,
// top_infinite, new_best, mutation_rate, stagnation_count) on the output channel
// (out_valid, out_stall). All other words only update the running minimum.
//
// Throughput is one word per cycle while in_stall is low. Each accepted word lands in
// an input register; from there one compare against the running minimum, the best and
// stagnation compares and the rate multiply by the constant factors finish and, for a
// last word, fill the result register, from which the result is offered.
//
// When the receiver stalls, the result register holds its word. Words that are not
// last keep flowing meanwhile; a last word waits in the input register, and only then
// does in_stall rise. Configuration writes (cfg_valid, cfg_index, cfg_data) are always
// taken (cfg_ready is high) and are meant for idle periods. Reset clears the running
// minimum, the stored best and previous top to infinite, the rate to its reset floor
// and the stagnation count to zero; both channels come up empty.
module generation_best_and_mutation_rate
    import gbmr_pkg::*;
#(
    parameter int MAX_INDIVIDUALS = 1024
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    // Configuration write channel
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    // Input channel
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic [LOSS_W-1:0]     loss,
    input  logic                  loss_infinite,
    input  logic                  last,
    // Output channel
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [INDEX_W-1:0]    top_index,
    output logic [LOSS_W-1:0]     min_loss,
    output logic                  top_infinite,
    output logic                  new_best,
    output logic [RATE_W-1:0]     mutation_rate,
    output logic [STAG_W-1:0]     stagnation_count
);

    localparam int CNT_W = (MAX_INDIVIDUALS > 1) ? $clog2(MAX_INDIVIDUALS) : 1;
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(MAX_INDIVIDUALS - 1);

    // Configuration registers.
    logic [LOSS_W-1:0] threshold_reg;
    logic [RATE_W-1:0] min_rate_reg;
    logic [RATE_W-1:0] max_rate_reg;

    // Input stage.
    logic              s1_valid_reg, s1_valid_next;
    logic [LOSS_W-1:0] s1_loss_reg;
    logic              s1_inf_reg;
    logic              s1_last_reg;

    // Generation and history state.
    logic [LOSS_W-1:0] run_min_reg, run_min_next;
    logic              run_inf_reg, run_inf_next;
    logic [CNT_W-1:0]  run_idx_reg, run_idx_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [LOSS_W-1:0] best_reg, best_next;
    logic              best_inf_reg, best_inf_next;
    logic [LOSS_W-1:0] prev_reg, prev_next;
    logic              prev_inf_reg, prev_inf_next;
    logic [RATE_W-1:0] rate_reg, rate_next;
    logic [STAG_W-1:0] stag_reg, stag_next;

    // Result stage.
    logic               out_valid_reg, out_valid_next;
    logic [INDEX_W-1:0] out_index_reg;
    logic [LOSS_W-1:0]  out_loss_reg;
    logic               out_inf_reg;
    logic               out_best_reg;

    // Datapath signals.
    logic              advance;
    logic              finish;
    logic              in_accept;
    logic              take;
    logic [LOSS_W-1:0] cur_min;
    logic              cur_inf;
    logic [CNT_W-1:0]  cur_idx;
    logic              is_best;
    logic [LOSS_W-1:0] diff;
    logic              stagnant;
    logic [PROD_W-1:0] grow_prod;
    logic [PROD_W-1:0] decay_prod;
    logic [RATE_W:0]   grow_rate;
    logic [RATE_W-1:0] decay_rate;
    logic [RATE_W-1:0] grow_capped;
    logic [RATE_W-1:0] decay_floored;

    // ------------------------------------------------------------------
    // Handshake. The input register moves on unless it holds a last word
    // while the result register is full and stalled.
    // ------------------------------------------------------------------
    assign advance   = s1_valid_reg && !(s1_last_reg && out_valid_reg && out_stall);
    assign finish    = advance && s1_last_reg;
    assign in_stall  = s1_valid_reg && !advance;
    assign in_accept = in_valid && !in_stall;
    assign cfg_ready = 1'b1;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (!in_stall)
        begin
            s1_valid_next = in_valid;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg && out_stall;
        if (finish)
        begin
            out_valid_next = 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // Running minimum. Infinite words carry zero loss bits, so an infinite
    // value always reads as zero. Ties go to the later word.
    // ------------------------------------------------------------------
    assign take    = run_inf_reg || (!s1_inf_reg && (s1_loss_reg <= run_min_reg));
    assign cur_min = take ? s1_loss_reg : run_min_reg;
    assign cur_inf = take ? s1_inf_reg  : run_inf_reg;
    assign cur_idx = take ? count_reg   : run_idx_reg;

    // The generation's top against the stored best and the previous top.
    assign is_best  = best_inf_reg || (!cur_inf && (cur_min <= best_reg));
    assign diff     = (cur_min >= prev_reg) ? (cur_min - prev_reg) : (prev_reg - cur_min);
    assign stagnant = !cur_inf && !prev_inf_reg && (diff < threshold_reg);

    // Both rate candidates come from the stored rate alone, rounded to nearest.
    assign grow_prod  = PROD_W'(rate_reg) * PROD_W'(GROW_Q16) + ROUND_HALF;
    assign decay_prod = PROD_W'(rate_reg) * PROD_W'(DECAY_Q16) + ROUND_HALF;
    assign grow_rate  = grow_prod[PROD_W-1:RATE_W];
    assign decay_rate = decay_prod[RATE_W+RATE_W-1:RATE_W];

    assign grow_capped   = (grow_rate > {1'b0, max_rate_reg}) ? max_rate_reg
                                                              : grow_rate[RATE_W-1:0];
    assign decay_floored = (decay_rate < min_rate_reg) ? min_rate_reg : decay_rate;

    always_comb
    begin
        run_min_next  = run_min_reg;
        run_inf_next  = run_inf_reg;
        run_idx_next  = run_idx_reg;
        count_next    = count_reg;
        best_next     = best_reg;
        best_inf_next = best_inf_reg;
        prev_next     = prev_reg;
        prev_inf_next = prev_inf_reg;
        rate_next     = rate_reg;
        stag_next     = stag_reg;
        if (advance)
        begin
            if (s1_last_reg)
            begin
                // Close the generation and start the next one fresh.
                run_min_next  = '0;
                run_inf_next  = 1'b1;
                run_idx_next  = '0;
                count_next    = '0;
                prev_next     = cur_min;
                prev_inf_next = cur_inf;
                if (is_best)
                begin
                    best_next     = cur_min;
                    best_inf_next = cur_inf;
                end
                if (stagnant)
                begin
                    rate_next = grow_capped;
                    stag_next = (stag_reg == STAG_MAX) ? stag_reg : stag_reg + 1'b1;
                end
                else
                begin
                    rate_next = decay_floored;
                    stag_next = '0;
                end
            end
            else
            begin
                run_min_next = cur_min;
                run_inf_next = cur_inf;
                run_idx_next = cur_idx;
                count_next   = (count_reg < CNT_LAST) ? count_reg + 1'b1 : count_reg;
            end
        end
    end

    // ------------------------------------------------------------------
    // Control and state registers.
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg <= THRESHOLD_RST;
            min_rate_reg  <= MIN_RATE_RST;
            max_rate_reg  <= MAX_RATE_RST;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            run_min_reg   <= '0;
            run_inf_reg   <= 1'b1;
            run_idx_reg   <= '0;
            count_reg     <= '0;
            best_reg      <= '0;
            best_inf_reg  <= 1'b1;
            prev_reg      <= '0;
            prev_inf_reg  <= 1'b1;
            rate_reg      <= MIN_RATE_RST;
            stag_reg      <= '0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    CFG_THRESHOLD: threshold_reg <= cfg_data;
                    CFG_MIN_RATE:  min_rate_reg  <= cfg_data[RATE_W-1:0];
                    CFG_MAX_RATE:  max_rate_reg  <= cfg_data[RATE_W-1:0];
                    default:       ;
                endcase
            end
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
            run_min_reg   <= run_min_next;
            run_inf_reg   <= run_inf_next;
            run_idx_reg   <= run_idx_next;
            count_reg     <= count_next;
            best_reg      <= best_next;
            best_inf_reg  <= best_inf_next;
            prev_reg      <= prev_next;
            prev_inf_reg  <= prev_inf_next;
            rate_reg      <= rate_next;
            stag_reg      <= stag_next;
        end
    end

    // Payload registers: the input word and the result word.
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_loss_reg <= loss_infinite ? '0 : loss;
            s1_inf_reg  <= loss_infinite;
            s1_last_reg <= last;
        end
        if (finish)
        begin
            out_index_reg <= INDEX_W'(cur_idx);
            out_loss_reg  <= cur_min;
            out_inf_reg   <= cur_inf;
            out_best_reg  <= is_best;
        end
    end

    // The rate and stagnation count shown are the registers after the update.
    assign out_valid        = out_valid_reg;
    assign top_index        = out_index_reg;
    assign min_loss         = out_loss_reg;
    assign top_infinite     = out_inf_reg;
    assign new_best         = out_best_reg;
    assign mutation_rate    = rate_reg;
    assign stagnation_count = stag_reg;

endmodule

@@ src/gbmr_checker.sv @@
// Port-level checker for the generation best and mutation rate block, with its bind.
module gbmr_checker
    import gbmr_pkg::*;
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  out_valid,
    input logic                  out_stall,
    input logic [INDEX_W-1:0]    top_index,
    input logic [LOSS_W-1:0]     min_loss,
    input logic                  top_infinite,
    input logic                  new_best,
    input logic [RATE_W-1:0]     mutation_rate,
    input logic [STAG_W-1:0]     stagnation_count
);

    // A stalled result word stays offered.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result word dropped while stalled");

    // A stalled result word does not change.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(top_index) && $stable(min_loss)
            && $stable(top_infinite) && $stable(new_best)
            && $stable(mutation_rate) && $stable(stagnation_count))
        else $error("result word changed while stalled");

    // An infinite top carries zero loss bits.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && top_infinite |-> min_loss == '0)
        else $error("infinite top with nonzero loss");

    // A generation with an infinite top can never be stagnant.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && top_infinite |-> stagnation_count == '0)
        else $error("stagnation counted on an infinite top");

endmodule

bind generation_best_and_mutation_rate gbmr_checker u_gbmr_checker (.*);
